// ----- hdl/rpd_pkg.sv -----
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types, character codes and the hex digit decoder for the packet
// deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

   localparam int unsigned CapWidth   = 13;
   localparam int unsigned CountWidth = 12;

   localparam logic [CapWidth-1:0] CapReset = 13'd1200;
   localparam logic [CapWidth-1:0] CapMax   = 13'd4096;

   localparam logic [7:0] ChStart = 8'h24;
   localparam logic [7:0] ChEnd   = 8'h23;
   localparam logic [7:0] ChAck   = 8'h2B;
   localparam logic [7:0] ChNak   = 8'h2D;

   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_DATA = 2'd1,
      PH_HI   = 2'd2,
      PH_LO   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [CountWidth-1:0] payload_length;
      logic                  checksum_ok;
      logic                  is_ack;
      logic [7:0]            out_byte;
   } res_type;

   // bit 4 set marks a character that is not a hex digit
   function automatic logic [4:0] digit_of(input logic [7:0] ch);
      logic [4:0] d;
      d = 5'h10;
      if (ch >= 8'h30 && ch <= 8'h39) begin
         d = 5'(ch - 8'h30);
      end else if (ch >= 8'h61 && ch <= 8'h66) begin
         d = 5'(ch - 8'h61 + 8'd10);
      end else if (ch >= 8'h41 && ch <= 8'h46) begin
         d = 5'(ch - 8'h41 + 8'd10);
      end
      return d;
   endfunction

endpackage

// ----- hdl/rsp_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// rsp_packet_deframer
// An accepted character passes the input register, then the result register,
// on its way to rsp_. Throughput: one character per cycle unless rsp_tready
// stalls, set by the input register, the state machine and the result register.
// Reset: synchronous; hunts for '$', capacity register returns to 1200.
// ----------------------------------------------------------------------------
module rsp_packet_deframer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,  // [7:0] rx_byte
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [23:0]                  rsp_tdata,  // [7:0] out_byte, [8] checksum_ok,
                                                    // [20:9] payload_length, [23:21] zero
   output logic                         rsp_tuser,  // [0] is_ack
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rpd_pkg::CapWidth-1:0] csr_wdata   // buffer_capacity
);
   import rpd_pkg::*;

   logic [CapWidth-1:0] cap_ff;
   logic                res_valid;
   logic                res_ready;
   res_type             res;
   res_type             out_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CapReset;
      end else if (csr_valid) begin
         cap_ff <= csr_wdata;
      end
   end

   rpd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .capacity  (cap_ff),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   rpd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   assign rsp_tdata = {3'b000, out_res.payload_length, out_res.checksum_ok, out_res.out_byte};
   assign rsp_tuser = out_res.is_ack;

endmodule

// ----- hdl/rpd_core.sv -----
// ----------------------------------------------------------------------------
// rpd_core
// Input register, framing state machine, checksum and length tracking.
// Produces at most one result per character.
// ----------------------------------------------------------------------------
module rpd_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [7:0]                         in_byte,
   input  logic [rpd_pkg::CapWidth-1:0]       capacity,
   output logic                               res_valid,
   input  logic                               res_ready,
   output rpd_pkg::res_type                   res
);
   import rpd_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [7:0]            in_byte_ff;
   phase_type             phase_ff, phase_in;
   logic [7:0]            sum_ff, sum_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [4:0]            nibble_ff, nibble_in;

   logic                  step;
   logic [CapWidth-1:0]   cap_eff;
   logic                  room;
   logic [4:0]            lo_digit;
   logic [3:0]            hi_value;
   logic [7:0]            want;
   logic                  ok;

   assign cap_eff  = (capacity > CapMax) ? CapMax : capacity;
   assign room     = ({1'b0, count_ff} + 13'd1) < cap_eff;
   assign lo_digit = digit_of(in_byte_ff);
   assign hi_value = nibble_ff[4] ? 4'hF : nibble_ff[3:0];
   assign want     = lo_digit[4] ? 8'hFF : {hi_value, lo_digit[3:0]};
   assign ok       = (want == sum_ff);

   assign step     = in_valid_ff && (res_ready || !res_valid);
   assign in_ready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (in_ready) begin
         in_valid_in = in_valid;
      end
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PH_HUNT: if (in_byte_ff == ChStart) phase_in = PH_DATA;
            PH_DATA: if (in_byte_ff == ChEnd) phase_in = PH_HI;
            PH_HI:   phase_in = PH_LO;
            PH_LO:   phase_in = PH_HUNT;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // outputs and datapath
   always_comb begin
      sum_in     = sum_ff;
      count_in   = count_ff;
      nibble_in  = nibble_ff;
      res_valid  = 1'b0;
      res        = '0;
      res.out_byte = in_byte_ff;
      case (phase_ff)
         PH_HUNT: begin
            if (in_byte_ff == ChStart) begin
               sum_in    = '0;
               count_in  = '0;
               nibble_in = '0;
            end
         end
         PH_DATA: begin
            if (in_byte_ff != ChEnd) begin
               sum_in    = sum_ff + in_byte_ff;
               res_valid = in_valid_ff && room;
               if (room) begin
                  count_in = count_ff + 12'd1;
               end
            end
         end
         PH_HI: begin
            nibble_in = lo_digit;
         end
         PH_LO: begin
            res_valid          = in_valid_ff;
            res.out_byte       = ok ? ChAck : ChNak;
            res.is_ack         = 1'b1;
            res.checksum_ok    = ok;
            res.payload_length = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         phase_ff    <= PH_HUNT;
         sum_ff      <= '0;
         count_ff    <= '0;
         nibble_ff   <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         phase_ff    <= phase_in;
         if (step) begin
            sum_ff    <= sum_in;
            count_ff  <= count_in;
            nibble_ff <= nibble_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         in_byte_ff <= in_byte;
      end
   end

   a_ack_only_in_lo: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.is_ack) |-> (phase_ff == PH_LO))
      else $error("ack result outside second checksum digit");

   a_hunt_after_ack: assert property (@(posedge clock) disable iff (reset)
      (step && phase_ff == PH_LO) |=> (phase_ff == PH_HUNT))
      else $error("no return to hunting after ack");

   a_count_tracks_emit: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && !res.is_ack) |=> (count_ff == $past(count_ff) + 12'd1))
      else $error("byte count out of step with emitted payload");

   a_count_below_cap: assert property (@(posedge clock) disable iff (reset)
      (step && res_valid && !res.is_ack) |-> ({1'b0, count_ff} + 13'd1 < cap_eff))
      else $error("payload byte emitted beyond capacity");

endmodule

// ----- hdl/rpd_out_stage.sv -----
// ----------------------------------------------------------------------------
// rpd_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rpd_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             res_valid,
   output logic             res_ready,
   input  rpd_pkg::res_type res,
   output logic             out_valid,
   input  logic             out_ready,
   output rpd_pkg::res_type out_res
);
   import rpd_pkg::*;

   logic    valid_ff, valid_in;
   res_type res_ff;

   assign res_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (res_ready) begin
         valid_in = res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         res_ff <= res;
      end
   end

endmodule
